FILE: rtl/deq_pkg.sv
`default_nettype none
package deq_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = 1;
	localparam int CQ_CNT_W = 2;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_PRIME,
		B_LIST
	} back_state_t;

	typedef struct packed {
		op_t                     op;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
		if (s >= (CNT_W+1)'(DEPTH)) begin
			s = s - (CNT_W+1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] a);
		logic [IDX_W-1:0] r;
		if (a == '0) begin
			r = IDX_W'(DEPTH - 1);
		end else begin
			r = a - IDX_W'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/deq_front.sv
`default_nettype none
module deq_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       kind,
	input  wire logic signed [deq_pkg::VAL_W-1:0] value,
	output logic                                  cmd_valid,
	output deq_pkg::cmd_t                         cmd,
	input  wire logic                             cmd_take
);
	import deq_pkg::*;

	cmd_t                slot_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                push;
	logic                pop;
	cmd_t                in_cmd;

	// decode the operation code
	always_comb begin
		in_cmd.op    = op_t'(kind);
		in_cmd.value = value;
	end

	assign busy      = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_take && cmd_valid;
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + CQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + CQ_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CQ_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CQ_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/deq_back.sv
`default_nettype none
module deq_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_valid,
	input  wire deq_pkg::cmd_t               cmd,
	output logic                             cmd_take,
	output logic                             strobe,
	output logic [1:0]                       status,
	output logic signed [deq_pkg::VAL_W-1:0] element,
	output logic                             is_empty,
	output logic                             is_last
);
	import deq_pkg::*;

	back_state_t      state_q;
	back_state_t      state_d;
	cmd_t             cmd_q;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] cnt_q;
	status_t          status_q;
	logic [CNT_W-1:0] k_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [VAL_W-1:0] rd_data_q;
	logic [VAL_W-1:0] mem [DEPTH];

	logic             full;
	logic             empty;
	logic             last;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W-1:0] rd_addr;
	status_t          exec_status;
	logic [IDX_W-1:0] front_d;
	logic [CNT_W-1:0] cnt_d;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign last  = ((k_q + CNT_W'(1)) == cnt_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:  if (cmd_valid) state_d = B_EXEC;
			B_EXEC:  state_d = B_PRIME;
			B_PRIME: state_d = empty ? B_IDLE : B_LIST;
			B_LIST:  if (last) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// operation datapath
	always_comb begin
		exec_status = ST_OK;
		we          = 1'b0;
		waddr       = front_q;
		front_d     = front_q;
		cnt_d       = cnt_q;
		unique case (cmd_q.op)
			OP_PUSH_FRONT: begin
				if (full) begin
					exec_status = ST_OVERFLOW;
				end else begin
					waddr   = wrap_dec(front_q);
					we      = 1'b1;
					front_d = waddr;
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					exec_status = ST_OVERFLOW;
				end else begin
					waddr = wrap_add(front_q, cnt_q);
					we    = 1'b1;
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					exec_status = ST_UNDERFLOW;
				end else begin
					front_d = wrap_add(front_q, CNT_W'(1));
					cnt_d   = cnt_q - CNT_W'(1);
				end
			end
			default: begin
				if (empty) begin
					exec_status = ST_UNDERFLOW;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
		endcase
	end

	always_comb begin
		cmd_take = (state_q == B_IDLE) && cmd_valid;
		rd_addr  = (state_q == B_PRIME) ? front_q : wrap_add(rd_ptr_q, CNT_W'(1));
		strobe   = ((state_q == B_PRIME) && empty) || (state_q == B_LIST);
		status   = status_q;
		is_empty = empty;
		is_last  = empty || last;
		element  = empty ? '0 : $signed(rd_data_q);
	end

	always_ff @(posedge clk) begin
		if ((state_q == B_EXEC) && we) begin
			mem[waddr] <= cmd_q.value;
		end
		rd_data_q <= mem[rd_addr];
		rd_ptr_q  <= rd_addr;
		if (cmd_take) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			front_q  <= '0;
			cnt_q    <= '0;
			status_q <= ST_OK;
			k_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_EXEC) begin
				front_q  <= front_d;
				cnt_q    <= cnt_d;
				status_q <= exec_status;
			end
			if (state_q == B_PRIME) begin
				k_q <= '0;
			end else if (state_q == B_LIST) begin
				k_q <= k_q + CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/double_ended_queue_top.sv
// the back sequencer takes a queued command only when idle, then steps through execute,
// read-prime and one ring read per element listed, and takes no new command until it is done;
// results are strobed in read-prime when the deque is empty, else once per listed element
// a two-item command queue lets start be taken while the back lists; results cannot stall
// reset clears front index, element count, command queue and sequencer; ring contents undefined
`default_nettype none
module double_ended_queue_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       kind,
	input  wire logic signed [deq_pkg::VAL_W-1:0] value,
	output logic                                  strobe,
	output logic [1:0]                            status,
	output logic signed [deq_pkg::VAL_W-1:0]      element,
	output logic                                  is_empty,
	output logic                                  is_last
);
	import deq_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_take;

	deq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.value     (value),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	deq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.strobe    (strobe),
		.status    (status),
		.element   (element),
		.is_empty  (is_empty),
		.is_last   (is_last)
	);

endmodule
`default_nettype wire
